// File: hw/rtl/wstm_pkg.sv
`default_nettype none
package wstm_pkg;
  localparam int TableEntriesDefault = 32;
  localparam int CounterBitsDefault  = 24;
  localparam int MacW    = 48;
  localparam int PosW    = 12;
  localparam logic [PosW-1:0] PosMax = 12'd4095;
  localparam logic [PosW-1:0] MinLen = 12'd22;

  localparam logic [1:0] ActByte  = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [2:0] StShort   = 3'd0;
  localparam logic [2:0] StOther   = 3'd1;
  localparam logic [2:0] StWds     = 3'd2;
  localparam logic [2:0] StBridged = 3'd3;
  localparam logic [2:0] StDone    = 3'd4;

  // One learning request handed from the frame parser to the table engine.
  typedef struct packed {
    logic            en;
    logic [MacW-1:0] mac;
    logic            up;
    logic            hs;
  } learn_req_t;

  function automatic logic [7:0] llc_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0, 3'd1: b = 8'hAA;
      3'd2:       b = 8'h03;
      3'd6:       b = 8'h88;
      3'd7:       b = 8'h8E;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/wstm_parser.sv
`default_nettype none
module wstm_parser (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     byte_en,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     last_byte,
  input  wire logic [wstm_pkg::MacW-1:0] target_bssid,
  output logic                          done,
  output logic [2:0]                    status,
  output logic                          eapol,
  output wstm_pkg::learn_req_t          req0,
  output wstm_pkg::learn_req_t          req1
);
  import wstm_pkg::*;

  logic [PosW-1:0] pos_r;
  logic [15:0]     fc_r;
  logic [MacW-1:0] a0_r, a1_r, a2_r;
  logic [7:0]      llc_r;
  logic [15:0]     fc;
  logic [MacW-1:0] a0, a1, a2;
  logic [7:0]      llc;
  logic [PosW-1:0] pos_n;
  logic [4:0]      hlen;
  logic [PosW-1:0] rel;
  logic            to_ds, from_ds, bc, mc;
  logic [MacW-1:0] bssid;

  // Fold the current byte into the header fields.
  always_comb begin
    fc = fc_r; a0 = a0_r; a1 = a1_r; a2 = a2_r; llc = llc_r;
    hlen = 5'd0; rel = '0;
    if (pos_r == 12'd0) fc[7:0] = data_byte;
    else if (pos_r == 12'd1) fc[15:8] = data_byte;
    else if (pos_r >= 12'd4 && pos_r < 12'd10) a0 = {a0_r[39:0], data_byte};
    else if (pos_r >= 12'd10 && pos_r < 12'd16) a1 = {a1_r[39:0], data_byte};
    else if (pos_r >= 12'd16 && pos_r < 12'd22) a2 = {a2_r[39:0], data_byte};
    else if (pos_r >= 12'd24 && pos_r < 12'd34) begin
      if (fc_r[7:4] == 4'd8) hlen = 5'd26;
      else if (fc_r[7:4] == 4'd0) hlen = 5'd24;
      rel = pos_r - {7'd0, hlen};
      if (hlen != 5'd0 && pos_r >= {7'd0, hlen} && rel < 12'd8 &&
          data_byte == llc_byte(rel[2:0]))
        llc[rel[2:0]] = 1'b1;
    end
    pos_n = (pos_r < PosMax) ? pos_r + 12'd1 : pos_r;
  end

  // Header registers; cleared at frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; fc_r <= '0; a0_r <= '0; a1_r <= '0; a2_r <= '0; llc_r <= '0;
    end else if (byte_en) begin
      if (last_byte) begin
        pos_r <= '0; fc_r <= '0; a0_r <= '0; a1_r <= '0; a2_r <= '0; llc_r <= '0;
      end else begin
        pos_r <= pos_n; fc_r <= fc; a0_r <= a0; a1_r <= a1; a2_r <= a2;
        llc_r <= llc;
      end
    end
  end

  // Frame end classification, from the updated fields.
  always_comb begin
    to_ds = fc[8]; from_ds = fc[9];
    bc = (a0 == {MacW{1'b1}});
    mc = a0[40];
    bssid = from_ds ? a1 : (to_ds ? a0 : a2);
    done = byte_en && last_byte;
    eapol = 1'b0;
    req0 = '0; req1 = '0;
    if (pos_n < MinLen) status = StShort;
    else if (to_ds && from_ds) status = StWds;
    else if (bssid != target_bssid) status = StOther;
    else begin
      eapol = (fc[3:2] == 2'd2) && !fc[14] &&
              (fc[7:4] == 4'd8 || fc[7:4] == 4'd0) && (llc == 8'hFF);
      if ((bc || mc) && a1 == target_bssid) status = StBridged;
      else begin
        status = StDone;
        if (to_ds) begin
          req0 = '{en: a1 != target_bssid, mac: a1, up: 1'b1, hs: eapol};
        end else if (from_ds) begin
          req0 = '{en: !bc && a0 != target_bssid, mac: a0, up: 1'b0, hs: eapol};
        end else begin
          req0 = '{en: a1 != target_bssid, mac: a1, up: 1'b1, hs: eapol};
          req1 = '{en: !bc && !mc && a0 != target_bssid, mac: a0, up: 1'b0,
                   hs: eapol};
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/wstm_table.sv
`default_nettype none
module wstm_table #(
  parameter int TABLE_ENTRIES = wstm_pkg::TableEntriesDefault,
  parameter int COUNTER_BITS  = wstm_pkg::CounterBitsDefault,
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CntW = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [wstm_pkg::MacW-1:0] target_bssid,
  input  wire logic                      frame_go,
  input  wire logic [2:0]                frame_status,
  input  wire logic                      frame_eapol,
  input  wire wstm_pkg::learn_req_t      req0_in,
  input  wire wstm_pkg::learn_req_t      req1_in,
  input  wire logic                      read_go,
  input  wire logic [4:0]                read_idx,
  input  wire logic                      clear_go,
  output logic                           busy,
  output logic                           out_strobe,
  output logic                           out_result_kind,
  output logic [2:0]                     out_frame_status,
  output logic                           out_eapol_seen,
  output logic                           out_station_dropped,
  output logic [5:0]                     out_station_count,
  output logic                           out_entry_valid,
  output logic [47:0]                    out_entry_mac,
  output logic [23:0]                    out_entry_uplink,
  output logic [23:0]                    out_entry_downlink,
  output logic [23:0]                    out_entry_handshakes
);
  import wstm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CHK = 3'd2,
                         S_WR = 3'd3, S_RD = 3'd4, S_RDO = 3'd5;
  localparam logic [COUNTER_BITS-1:0] CMax = {COUNTER_BITS{1'b1}};

  // Station memories, one read port each with registered data.
  logic [MacW-1:0]           mac_mem [TABLE_ENTRIES];
  logic [3*COUNTER_BITS-1:0] cnt_mem [TABLE_ENTRIES];
  logic [MacW-1:0]           mac_rd_r;
  logic [3*COUNTER_BITS-1:0] cnt_rd_r;
  logic [IdxW-1:0]           raddr;
  logic                      we;
  logic [IdxW-1:0]           waddr;
  logic [MacW-1:0]           wmac;
  logic [3*COUNTER_BITS-1:0] wcnt;

  logic [2:0]       st_r;
  logic [CntW-1:0]  used_r;
  logic [CntW-1:0]  i_r;
  learn_req_t       cur_r, nxt_r;
  logic             drop_r, eap_r, rdv_r;
  logic [2:0]       fst_r;
  logic [COUNTER_BITS-1:0] up_c, dn_c, hs_c;
  logic             skip;
  logic             kind_r;
  logic [MacW-1:0]  hold_mac_r;
  logic [COUNTER_BITS-1:0] hold_up_r, hold_dn_r, hold_hs_r;

  assign raddr = i_r[IdxW-1:0];
  always_ff @(posedge clk) begin
    if (we) begin
      mac_mem[waddr] <= wmac;
      cnt_mem[waddr] <= wcnt;
    end
    mac_rd_r <= mac_mem[raddr];
    cnt_rd_r <= cnt_mem[raddr];
  end

  assign up_c = cnt_rd_r[3*COUNTER_BITS-1:2*COUNTER_BITS];
  assign dn_c = cnt_rd_r[2*COUNTER_BITS-1:COUNTER_BITS];
  assign hs_c = cnt_rd_r[COUNTER_BITS-1:0];
  assign skip = (cur_r.mac[47:40] == 8'hFF) || cur_r.mac[40] ||
                (cur_r.mac == target_bssid);
  assign busy = (st_r != S_IDLE);

  // Write port: bump an existing entry or append a new one.
  always_comb begin
    we = 1'b0; waddr = i_r[IdxW-1:0]; wmac = cur_r.mac; wcnt = cnt_rd_r;
    if (st_r == S_CHK && i_r < used_r && mac_rd_r == cur_r.mac) begin
      we = 1'b1;
      wcnt = {(cur_r.up && up_c != CMax) ? up_c + 1'b1 : up_c,
              (!cur_r.up && dn_c != CMax) ? dn_c + 1'b1 : dn_c,
              (cur_r.hs && hs_c != CMax) ? hs_c + 1'b1 : hs_c};
    end else if (st_r == S_WR && used_r < CntW'(TABLE_ENTRIES)) begin
      we = 1'b1; waddr = used_r[IdxW-1:0];
      wcnt = {{(COUNTER_BITS-1){1'b0}}, cur_r.up,
              {(COUNTER_BITS-1){1'b0}}, !cur_r.up,
              {(COUNTER_BITS-1){1'b0}}, cur_r.hs};
    end
  end

  // Sequencer: scan entries one at a time for a frame, or fetch one for a read, then report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; i_r <= '0; cur_r <= '0; nxt_r <= '0;
      drop_r <= 1'b0; eap_r <= 1'b0; fst_r <= '0; rdv_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (st_r == S_RDO);
      unique case (st_r)
        S_IDLE: begin
          if (clear_go) used_r <= '0;
          else if (frame_go) begin
            fst_r <= frame_status; eap_r <= frame_eapol; drop_r <= 1'b0;
            cur_r <= req0_in; nxt_r <= req1_in; i_r <= '0;
            st_r <= S_SCAN;
          end else if (read_go) begin
            rdv_r <= ({1'b0, read_idx} < 6'(used_r)) &&
                     ({1'b0, read_idx} < 6'(TABLE_ENTRIES));
            i_r <= CntW'(read_idx);
            st_r <= S_RD;
          end
        end
        S_SCAN: begin
          if (!cur_r.en || skip) begin
            if (nxt_r.en) begin
              cur_r <= nxt_r; nxt_r <= '0; i_r <= '0;
            end else st_r <= S_RDO;
          end else if (i_r >= used_r) st_r <= S_WR;
          else st_r <= S_CHK;
        end
        S_CHK: begin
          if (mac_rd_r == cur_r.mac) begin
            cur_r.en <= 1'b0; st_r <= S_SCAN;
          end else begin
            i_r <= i_r + 1'b1; st_r <= S_SCAN;
          end
        end
        S_WR: begin
          if (used_r < CntW'(TABLE_ENTRIES)) used_r <= used_r + 1'b1;
          else drop_r <= 1'b1;
          cur_r.en <= 1'b0; st_r <= S_SCAN;
        end
        S_RD: st_r <= S_RDO;
        S_RDO: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Result fields, registered alongside the strobe.
  always_ff @(posedge clk) begin
    if (st_r == S_RDO) begin
      out_station_count <= 6'(used_r);
      out_result_kind   <= kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= 1'b0;
    else if (st_r == S_IDLE && !clear_go) begin
      if (frame_go) kind_r <= 1'b0;
      else if (read_go) kind_r <= 1'b1;
    end
  end

  always_comb begin
    out_frame_status = '0; out_eapol_seen = 1'b0; out_station_dropped = 1'b0;
    out_entry_valid = 1'b0; out_entry_mac = '0; out_entry_uplink = '0;
    out_entry_downlink = '0; out_entry_handshakes = '0;
    if (!kind_r) begin
      out_frame_status = fst_r; out_eapol_seen = eap_r;
      out_station_dropped = drop_r;
    end else if (rdv_r) begin
      out_entry_valid = 1'b1; out_entry_mac = hold_mac_r;
      out_entry_uplink = 24'(hold_up_r); out_entry_downlink = 24'(hold_dn_r);
      out_entry_handshakes = 24'(hold_hs_r);
    end
  end

  // Entry readout, held while the result is on the ports.
  always_ff @(posedge clk) begin
    if (st_r == S_RDO) begin
      hold_mac_r <= mac_rd_r; hold_up_r <= up_c; hold_dn_r <= dn_c;
      hold_hs_r <= hs_c;
    end
  end

`ifndef SYNTHESIS
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(TABLE_ENTRIES)) else $error("station count overflow");
  a_strobe_after_rdo: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r) == S_RDO) else $error("stray strobe");
  a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r) && used_r != '0) |-> used_r == $past(used_r) + 1'b1)
    else $error("table grew by more than one");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/wlan_station_traffic_monitor_unit.sv
// Sequence: a read reaches out_strobe through states S_RD and S_RDO; a frame end goes
// through S_SCAN, with S_SCAN and S_CHK for each table entry searched and S_WR for
// each new station to learn, then through S_RDO to out_strobe.
// Throughput: frame bytes that are not last are taken one per cycle; after a read
// or a frame end busy stays high until the strobe cycle, which can take the next.
// Results appear on out_strobe for one cycle; the receiver cannot stall.
// Reset (rst_n, synchronous) empties the table and clears the frame state.
`default_nettype none
module wlan_station_traffic_monitor_unit #(
  parameter int TABLE_ENTRIES = wstm_pkg::TableEntriesDefault,
  parameter int COUNTER_BITS  = wstm_pkg::CounterBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [47:0] cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [4:0]  in_entry_index,
  output logic             out_strobe,
  output logic             out_result_kind,
  output logic [2:0]       out_frame_status,
  output logic             out_eapol_seen,
  output logic             out_station_dropped,
  output logic [5:0]       out_station_count,
  output logic             out_entry_valid,
  output logic [47:0]      out_entry_mac,
  output logic [23:0]      out_entry_uplink,
  output logic [23:0]      out_entry_downlink,
  output logic [23:0]      out_entry_handshakes
);
  import wstm_pkg::*;

  logic [47:0] bssid_r;
  logic        acc, done, eapol;
  logic [2:0]  status;
  learn_req_t  r0, r1;

  // Target BSSID register.
  always_ff @(posedge clk) begin
    if (!rst_n) bssid_r <= '0;
    else if (cfg_we) bssid_r <= cfg_wdata;
  end

  assign acc = start && !busy;

  wstm_parser u_parser (
    .clk, .rst_n, .byte_en(acc && in_action == ActByte),
    .data_byte(in_data_byte), .last_byte(in_last_byte), .target_bssid(bssid_r),
    .done, .status, .eapol, .req0(r0), .req1(r1)
  );

  wstm_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNTER_BITS(COUNTER_BITS)) u_table (
    .clk, .rst_n, .target_bssid(bssid_r),
    .frame_go(done), .frame_status(status), .frame_eapol(eapol),
    .req0_in(r0), .req1_in(r1),
    .read_go(acc && in_action == ActRead), .read_idx(in_entry_index),
    .clear_go(acc && in_action == ActClear), .busy,
    .out_strobe, .out_result_kind, .out_frame_status, .out_eapol_seen,
    .out_station_dropped, .out_station_count, .out_entry_valid, .out_entry_mac,
    .out_entry_uplink, .out_entry_downlink, .out_entry_handshakes
  );
endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wstm_pkg::*;

  localparam int Entries  = 32;
  localparam int PoolSize = 44;
  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 160;
  localparam logic [47:0] Bcast = 48'hFFFF_FFFF_FFFF;
  localparam logic [23:0] CntMax = 24'hFF_FFFF;
  localparam logic [1:0] ActUnused = 2'd3;

  // One result transfer as it appears on the out_ ports.
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        eapol;
    logic        dropped;
    logic [5:0]  count;
    logic        valid;
    logic [47:0] mac;
    logic [23:0] up;
    logic [23:0] dn;
    logic [23:0] hs;
  } report_t;

  // Traffic-monitor predictor with a queue of expected reports.
  class monitor_scoreboard;
    logic [47:0] bssid;
    logic [11:0] pos;
    logic [15:0] fc;
    logic [47:0] addr [3];
    logic [7:0]  llc_hits;
    logic [47:0] macs [Entries];
    logic [23:0] up_cnt [Entries];
    logic [23:0] dn_cnt [Entries];
    logic [23:0] hs_cnt [Entries];
    int          used;
    report_t     pending_reports [$];
    int          mismatches;
    int          checked;

    function new();
      bssid = '0;
      used = 0;
      mismatches = 0;
      checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = '0;
      fc = '0;
      addr[0] = '0;
      addr[1] = '0;
      addr[2] = '0;
      llc_hits = '0;
    endfunction

    function int hdr_len();
      if (fc[7:4] == 4'd8) return 26;
      if (fc[7:4] == 4'd0) return 24;
      return 0;
    endfunction

    // Returns one when a new station could not be learned.
    function bit learn(logic [47:0] m, bit up, bit hsk);
      if (m[47:40] == 8'hFF || m[40]) return 0;
      if (m == bssid) return 0;
      for (int i = 0; i < used; i++) begin
        if (macs[i] == m) begin
          if (up) begin
            if (up_cnt[i] != CntMax) up_cnt[i]++;
          end else begin
            if (dn_cnt[i] != CntMax) dn_cnt[i]++;
          end
          if (hsk && hs_cnt[i] != CntMax) hs_cnt[i]++;
          return 0;
        end
      end
      if (used >= Entries) return 1;
      macs[used] = m;
      up_cnt[used] = up ? 24'd1 : 24'd0;
      dn_cnt[used] = up ? 24'd0 : 24'd1;
      hs_cnt[used] = hsk ? 24'd1 : 24'd0;
      used++;
      return 0;
    endfunction

    function void take_byte(logic [7:0] b);
      int p;
      int h;
      int a;
      p = pos;
      if (p == 0) fc[7:0] = b;
      else if (p == 1) fc[15:8] = b;
      else if (p >= 4 && p < 22) begin
        a = (p - 4) / 6;
        addr[a] = {addr[a][39:0], b};
      end else if (p >= 24 && p < 34) begin
        h = hdr_len();
        if (h != 0 && p >= h && p - h < 8 && b == llc_byte(3'(p - h)))
          llc_hits[p - h] = 1'b1;
      end
      if (pos != PosMax) pos++;
    endfunction

    function logic [2:0] finish(output bit eap, output bit drop);
      logic [47:0] ra;
      logic [47:0] ta;
      logic [47:0] bs;
      bit bc;
      bit mc;
      ra = addr[0];
      ta = addr[1];
      eap = 0;
      drop = 0;
      if (pos < MinLen) return StShort;
      if (fc[8] && fc[9]) return StWds;
      if (fc[9]) bs = ta;
      else if (fc[8]) bs = ra;
      else bs = addr[2];
      if (bs != bssid) return StOther;
      if (fc[3:2] == 2'd2 && !fc[14] && hdr_len() != 0 && llc_hits == 8'hFF) eap = 1;
      bc = (ra == Bcast);
      mc = ra[40];
      if ((bc || mc) && ta == bssid) return StBridged;
      if (fc[8]) begin
        if (ta != bssid) drop |= learn(ta, 1, eap);
      end else if (fc[9]) begin
        if (!bc && ra != bssid) drop |= learn(ra, 0, eap);
      end else begin
        if (ta != bssid) drop |= learn(ta, 1, eap);
        if (!bc && !mc && ra != bssid) drop |= learn(ra, 0, eap);
      end
      return StDone;
    endfunction

    // Notes an accepted input transfer and queues the report it causes.
    function void note(logic [1:0] act, logic [7:0] b, logic last, logic [4:0] idx);
      report_t r;
      bit eap;
      bit drop;
      r = '0;
      if (act == ActByte) begin
        take_byte(b);
        if (last) begin
          r.status = finish(eap, drop);
          r.eapol = eap;
          r.dropped = drop;
          r.count = 6'(used);
          clear_frame();
          pending_reports.push_back(r);
        end
      end else if (act == ActRead) begin
        r.kind = 1'b1;
        r.count = 6'(used);
        if (idx < used) begin
          r.valid = 1'b1;
          r.mac = macs[idx];
          r.up = up_cnt[idx];
          r.dn = dn_cnt[idx];
          r.hs = hs_cnt[idx];
        end
        pending_reports.push_back(r);
      end else if (act == ActClear) begin
        used = 0;
      end
    endfunction

    // Compares one result transfer with the oldest expected report.
    function void check(report_t got);
      report_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ActByte;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [4:0]  in_entry_index = '0;
  logic        out_strobe;
  report_t     out_rep;

  wlan_station_traffic_monitor_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_action(in_action), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .in_entry_index(in_entry_index),
    .out_strobe(out_strobe), .out_result_kind(out_rep.kind),
    .out_frame_status(out_rep.status), .out_eapol_seen(out_rep.eapol),
    .out_station_dropped(out_rep.dropped), .out_station_count(out_rep.count),
    .out_entry_valid(out_rep.valid), .out_entry_mac(out_rep.mac),
    .out_entry_uplink(out_rep.up), .out_entry_downlink(out_rep.dn),
    .out_entry_handshakes(out_rep.hs)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  monitor_scoreboard sb = new();
  int idle_cycles = 0;
  int frames_sent = 0;
  int reads_sent = 0;
  bit no_gaps = 0;
  logic [47:0] pool [PoolSize];

  // Sample both channels at the rising edge; results first, then the new input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check(out_rep);
      if (start && !busy) sb.note(in_action, in_data_byte, in_last_byte, in_entry_index);
      if (out_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("watchdog expired with %0d reports outstanding",
                 sb.pending_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drives one input transfer after a random gap, none while no_gaps is set, and waits until it is taken.
  task automatic send(logic [1:0] act, logic [7:0] b, logic last, logic [4:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    in_last_byte <= last;
    in_entry_index <= idx;
    do @(posedge clk); while (busy);
  endtask

  // Lets the block drain, then writes the BSSID register while idle.
  task automatic set_bssid(logic [47:0] v);
    @(negedge clk);
    start <= 1'b0;
    wait (sb.pending_reports.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.bssid = v;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] pick_addr();
    logic [47:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: m = pool[$urandom_range(0, PoolSize - 1)];
      6: m = sb.bssid;
      7: m = Bcast;
      8: begin
        m = rand48();
        m[40] = 1'b1;
      end
      default: m = rand48();
    endcase
    return m;
  endfunction

  task automatic new_pool();
    for (int i = 0; i < PoolSize; i++) begin
      pool[i] = rand48();
      pool[i][40] = 1'b0;
    end
  endtask

  // Sends a frame byte by byte, with occasional other transfers between bytes.
  task automatic send_frame(logic [7:0] fb [$]);
    for (int i = 0; i < fb.size(); i++) begin
      if ($urandom_range(0, 59) == 0) begin
        case ($urandom_range(0, 2))
          0: send(ActRead, 8'($urandom), 1'($urandom), 5'($urandom));
          1: send(ActClear, 8'($urandom), 1'($urandom), 5'($urandom));
          default: send(ActUnused, 8'($urandom), 1'($urandom), 5'($urandom));
        endcase
      end
      send(ActByte, fb[i], i == fb.size() - 1, 5'($urandom));
    end
    frames_sent++;
  endtask

  // Builds a data frame whose header mostly names the monitored BSSID.
  task automatic random_frame();
    logic [7:0]  fb [$];
    logic [7:0]  fc0;
    logic [7:0]  fc1;
    logic [47:0] a1;
    logic [47:0] a2;
    logic [47:0] a3;
    int          corrupt;
    int          len;
    fc0 = 8'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      fc0[3:2] = 2'd2;
      fc0[7:4] = $urandom_range(0, 1) ? 4'd8 : 4'd0;
    end
    fc1 = 8'($urandom);
    fc1[6] = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 19))
      0: fc1[1:0] = 2'b11;
      1, 2, 3, 4, 5, 6: fc1[1:0] = 2'b01;
      7, 8, 9, 10, 11, 12: fc1[1:0] = 2'b10;
      default: fc1[1:0] = 2'b00;
    endcase
    a1 = pick_addr();
    a2 = pick_addr();
    a3 = pick_addr();
    if ($urandom_range(0, 9) != 0) begin
      if (fc1[1:0] == 2'b10) a2 = sb.bssid;
      else if (fc1[1:0] == 2'b01) a1 = sb.bssid;
      else a3 = sb.bssid;
    end
    fb.push_back(fc0);
    fb.push_back(fc1);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    for (int i = 5; i >= 0; i--) fb.push_back(a1[i*8 +: 8]);
    for (int i = 5; i >= 0; i--) fb.push_back(a2[i*8 +: 8]);
    for (int i = 5; i >= 0; i--) fb.push_back(a3[i*8 +: 8]);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    if (fc0[7:4] == 4'd8) begin
      fb.push_back(8'($urandom));
      fb.push_back(8'($urandom));
    end
    corrupt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : -1;
    for (int i = 0; i < 8; i++)
      fb.push_back(i == corrupt ? 8'($urandom) : llc_byte(3'(i)));
    repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, fb.size());
      while (fb.size() > len) void'(fb.pop_back());
    end
    send_frame(fb);
  endtask

  // A frame of the given length with random content.
  task automatic noise_frame(int len);
    logic [7:0] fb [$];
    repeat (len) fb.push_back(8'($urandom));
    send_frame(fb);
  endtask

  initial begin
    logic [47:0] phase_bssid [6];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    new_pool();

    // Directed: empty-table reads, edge fields, frames at and below the minimum length and the odd actions.
    no_gaps = 1;
    send(ActRead, 8'h00, 1'b0, 5'd0);
    send(ActRead, 8'hFF, 1'b1, 5'd31);
    send(ActUnused, 8'hFF, 1'b1, 5'd31);
    send(ActClear, 8'h00, 1'b0, 5'd0);
    send(ActByte, 8'hFF, 1'b1, 5'd0);
    noise_frame(21);
    noise_frame(22);
    no_gaps = 0;
    for (int i = 0; i < 6; i++) random_frame();
    send(ActRead, 8'h00, 1'b0, 5'd0);

    phase_bssid[0] = '0;
    phase_bssid[1] = 48'hFFFF_FFFF_FFFF;
    phase_bssid[2] = 48'h0000_0000_0001;
    phase_bssid[3] = rand48();
    phase_bssid[4] = 48'hFE00_0000_0000;
    phase_bssid[5] = rand48();

    // Random phases: a new BSSID each time, mostly well-formed frames.
    for (int ph = 0; ph < 6; ph++) begin
      set_bssid(phase_bssid[ph]);
      new_pool();
      for (int n = 0; n < 7; n++) begin
        no_gaps = (n % 7) < 2;
        case ($urandom_range(0, 19))
          0: noise_frame($urandom_range(1, 40));
          1, 2, 3: begin
            send(ActRead, 8'($urandom), 1'($urandom), 5'($urandom));
            reads_sent++;
          end
          4: if ($urandom_range(0, 3) == 0) send(ActClear, 8'($urandom), 1'($urandom), 5'($urandom));
          default: random_frame();
        endcase
      end
      for (int i = 0; i < Entries; i++) send(ActRead, 8'($urandom), 1'($urandom), 5'(i));
      reads_sent += Entries;
    end

    @(negedge clk);
    start <= 1'b0;
    wait (sb.pending_reports.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d frames, %0d table reads, %0d results checked over 6 BSSIDs.",
             frames_sent, reads_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d reports missing", sb.mismatches,
               sb.pending_reports.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: wlan_station_traffic_monitor_unit.f
hw/rtl/wstm_pkg.sv
hw/rtl/wstm_parser.sv
hw/rtl/wstm_table.sv
hw/rtl/wlan_station_traffic_monitor_unit.sv
sim/tb.sv
